/* design/hal_pkg.sv */
// shared types and constants for the handshake admission limiter
// no dependencies; imported by every module of the block
`default_nettype none
package hal_pkg;

  localparam int BUCKETS   = 512;   // power of two, start bucket is the low hash bits
  localparam int KEY_BYTES = 16;
  localparam int BKT_W     = $clog2(BUCKETS);
  localparam int KB_W      = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int HASH_SEED = 5381;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_EMPTY_KEY = 3'd1,
    ST_GLOBAL    = 3'd2,
    ST_FULL      = 3'd3,
    ST_KEY_LIMIT = 3'd4,
    ST_RELEASED  = 3'd5,
    ST_NONE      = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CFG_MAX_PER_WINDOW = 2'd0,
    CFG_MAX_GLOBAL     = 2'd1,
    CFG_WINDOW_SECS    = 2'd2,
    CFG_BUCKET_TTL     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  max_per_window;
    logic [9:0]  max_global;
    logic [15:0] window_secs;
    logic [15:0] bucket_ttl;
  } cfg_t;

  typedef struct packed {
    logic             release_op;
    logic             empty;
    logic [63:0]      key_hi;
    logic [63:0]      key_lo;
    logic [31:0]      now;
    logic [BKT_W-1:0] start;
  } job_t;

  typedef struct packed {
    logic        used;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [31:0] wstart;
    logic [7:0]  count;
  } entry_t;

endpackage
`default_nettype wire

/* design/hal_front.sv */
// front end: accepts a transaction, normalizes the key and hashes it one byte a cycle
// depends on hal_pkg
`default_nettype none
module hal_front import hal_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [63:0] key_hi,
  input  wire logic [63:0] key_lo,
  input  wire logic [31:0] now_seconds,
  output logic             push_valid,
  input  wire logic        push_ready,
  output job_t             push_job
);

  typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} fstate_t;

  fstate_t          state;
  job_t             job;
  logic [KB_W-1:0]  bi;
  logic [BKT_W-1:0] h_next;
  logic [127:0]     rkey;
  logic [127:0]     nkey;
  logic [127:0]     skey;
  logic [7:0]       c;
  logic             run;

  assign rkey = {key_hi, key_lo};

  // keep each byte only while no zero byte came before it
  always_comb begin
    nkey = '0;
    run  = 1'b1;
    for (int i = 0; i < 16; i++) begin
      if (i < KEY_BYTES) begin
        run = run & (rkey[127-8*i -: 8] != 8'd0);
        if (run) nkey[127-8*i -: 8] = rkey[127-8*i -: 8];
      end
    end
  end

  assign skey = {job.key_hi, job.key_lo};
  assign c    = skey[127 - 8*bi -: 8];

  // only the low hash bits select the bucket, so the hash is kept that narrow
  always_comb begin
    h_next = job.start;
    if (c != 8'd0) h_next = (job.start << 5) + job.start + BKT_W'(c);
  end

  assign in_ready   = (state == F_IDLE);
  assign push_valid = (state == F_PUSH);
  assign push_job   = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            job.release_op <= action;
            job.empty      <= (nkey[127:120] == 8'd0);
            job.key_hi     <= nkey[127:64];
            job.key_lo     <= nkey[63:0];
            job.now        <= now_seconds;
            job.start      <= HASH_SEED[BKT_W-1:0];
            bi             <= '0;
            state <= (action || nkey[127:120] == 8'd0) ? F_PUSH : F_HASH;
          end
        end
        F_HASH: begin
          job.start <= h_next;
          if (bi == KB_W'(KEY_BYTES - 1)) begin
            state <= F_PUSH;
          end else begin
            bi <= bi + 1'b1;
          end
        end
        F_PUSH: begin
          if (push_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/hal_queue.sv */
// two-entry queue between the front end and the bucket engine
// depends on hal_pkg
`default_nettype none
module hal_queue import hal_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  job_t      wr_job,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output job_t      rd_job,
  output logic [1:0] level
);

  job_t slots [2];
  logic wp, rp;
  logic push, pop;

  assign wr_ready = (level != 2'd2);
  assign rd_valid = (level != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_job   = slots[rp];

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      level <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      level <= level + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

/* design/hal_back.sv */
// bucket engine: clearing pass, linear probe over the bucket memory, window
// check, in-flight count and output register; depends on hal_pkg
`default_nettype none
module hal_back import hal_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  cfg_t       cfg,
  input  wire logic  job_valid,
  output logic       job_ready,
  input  job_t       job_in,
  output logic       clearing,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic       out_granted,
  output status_t    out_status,
  output logic [9:0] out_inflight
);

  typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_PROBE, B_WIN} bstate_t;

  bstate_t          state;
  entry_t           mem [BUCKETS];
  entry_t           rd_q;
  logic             rd_vld;
  logic             rd_en;
  logic [BKT_W-1:0] rd_addr;
  logic             we;
  logic [BKT_W-1:0] waddr;
  entry_t           wdata;

  job_t             job;
  logic [BKT_W-1:0] clr;
  logic [BKT_W:0]   iss;
  logic [BKT_W:0]   chk;
  logic             have_stale;
  logic [BKT_W-1:0] stale_idx;
  logic [BKT_W-1:0] idx;
  entry_t           ent;
  logic [9:0]       inflight;

  logic [BKT_W-1:0] b;
  logic             hit, stale_now;
  entry_t           fresh, win_ent;
  logic             expired, limited;

  assign clearing  = (state == B_CLEAR);
  assign job_ready = (state == B_IDLE) && !out_valid;
  assign rd_en     = (state == B_PROBE) && (iss < (BKT_W+1)'(BUCKETS));
  assign rd_addr   = job.start + iss[BKT_W-1:0];
  assign b         = job.start + chk[BKT_W-1:0];

  assign hit       = rd_q.used && rd_q.key_hi == job.key_hi && rd_q.key_lo == job.key_lo;
  assign stale_now = {1'b0, job.now} >= {1'b0, rd_q.wstart} + 33'(cfg.bucket_ttl);

  always_comb begin
    fresh.used   = 1'b1;
    fresh.key_hi = job.key_hi;
    fresh.key_lo = job.key_lo;
    fresh.wstart = job.now;
    fresh.count  = 8'd0;
  end

  // window restart, then per-key limit
  always_comb begin
    expired = {1'b0, job.now} >= {1'b0, ent.wstart} + 33'(cfg.window_secs);
    win_ent = ent;
    if (expired) begin
      win_ent.wstart = job.now;
      win_ent.count  = 8'd0;
    end
    limited = (win_ent.count >= cfg.max_per_window);
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = win_ent;
    if (state == B_CLEAR) begin
      we    = 1'b1;
      waddr = clr;
      wdata = '0;
    end else if (state == B_WIN) begin
      we = 1'b1;
      if (!limited) wdata.count = win_ent.count + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr       <= '0;
      rd_vld    <= 1'b0;
      inflight  <= '0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        B_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == BKT_W'(BUCKETS - 1)) state <= B_IDLE;
        end
        B_IDLE: begin
          if (job_valid && !out_valid) begin
            job         <= job_in;
            out_granted <= 1'b0;
            iss         <= '0;
            chk         <= '0;
            have_stale  <= 1'b0;
            if (job_in.release_op) begin
              out_valid <= 1'b1;
              if (inflight != 10'd0) begin
                inflight     <= inflight - 10'd1;
                out_inflight <= inflight - 10'd1;
                out_status   <= ST_RELEASED;
              end else begin
                out_inflight <= inflight;
                out_status   <= ST_NONE;
              end
            end else if (job_in.empty) begin
              out_valid    <= 1'b1;
              out_inflight <= inflight;
              out_status   <= ST_EMPTY_KEY;
            end else if (inflight >= cfg.max_global) begin
              out_valid    <= 1'b1;
              out_inflight <= inflight;
              out_status   <= ST_GLOBAL;
            end else begin
              state <= B_PROBE;
            end
          end
        end
        B_PROBE: begin
          if (rd_en) iss <= iss + 1'b1;
          if (rd_vld) begin
            chk <= chk + 1'b1;
            if (hit) begin
              idx   <= b;
              ent   <= rd_q;
              state <= B_WIN;
            end else if (!rd_q.used) begin
              idx   <= b;
              ent   <= fresh;
              state <= B_WIN;
            end else begin
              if (!have_stale && stale_now) begin
                have_stale <= 1'b1;
                stale_idx  <= b;
              end
              if (chk == (BKT_W+1)'(BUCKETS - 1)) begin
                if (have_stale || stale_now) begin
                  idx   <= have_stale ? stale_idx : b;
                  ent   <= fresh;
                  state <= B_WIN;
                end else begin
                  out_valid    <= 1'b1;
                  out_inflight <= inflight;
                  out_status   <= ST_FULL;
                  state        <= B_IDLE;
                end
              end
            end
          end
        end
        B_WIN: begin
          out_valid <= 1'b1;
          if (limited) begin
            out_inflight <= inflight;
            out_status   <= ST_KEY_LIMIT;
          end else begin
            inflight     <= inflight + 10'd1;
            out_inflight <= inflight + 10'd1;
            out_status   <= ST_GRANTED;
            out_granted  <= 1'b1;
          end
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/handshake_admission_limiter_top.sv */
// top level of the handshake admission limiter: config registers, front end,
// queue and bucket engine; depends on hal_pkg, hal_front, hal_queue, hal_back
`default_nettype none
// Admission control for handshake starts: per-key fixed-window limit plus a
// global in-flight cap, over a 512-bucket linearly probed table. After reset
// a clearing pass runs through the bucket memory and no transaction is
// accepted meanwhile; config writes are taken at any time. A release or
// empty-key item skips the hash and goes to the queue directly. A reserve runs
// through the byte-serial hash, then probes one bucket per cycle on the single
// memory read port, so its result waits on the number of probed buckets; a
// search of the whole table reads every bucket.
module handshake_admission_limiter_top import hal_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [159:0] s_tdata,  // key_hi[63:0], key_lo[127:64], now_seconds[159:128]
  input  wire logic         s_tuser,  // action
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [15:0]       m_tdata,  // inflight_count[9:0], zero fill
  output logic [3:0]        m_tuser   // granted[0], status[3:1]
);

  cfg_t       cfg;
  logic       f_ready, clearing;
  logic       push_valid, push_ready;
  job_t       push_job, pop_job;
  logic       pop_valid, pop_ready;
  logic [1:0] level;
  logic       granted;
  status_t    status;
  logic [9:0] inflight;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_per_window <= 8'd30;
      cfg.max_global     <= 10'd256;
      cfg.window_secs    <= 16'd60;
      cfg.bucket_ttl     <= 16'd120;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAX_PER_WINDOW: cfg.max_per_window <= cfg_data[7:0];
        CFG_MAX_GLOBAL:     cfg.max_global     <= cfg_data[9:0];
        CFG_WINDOW_SECS:    cfg.window_secs    <= cfg_data;
        CFG_BUCKET_TTL:     cfg.bucket_ttl     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = f_ready && !clearing;

  hal_front u_front (
    .clk, .rst,
    .in_valid(s_tvalid && !clearing), .in_ready(f_ready),
    .action(s_tuser), .key_hi(s_tdata[63:0]), .key_lo(s_tdata[127:64]),
    .now_seconds(s_tdata[159:128]),
    .push_valid, .push_ready, .push_job
  );

  hal_queue u_queue (
    .clk, .rst,
    .wr_valid(push_valid), .wr_ready(push_ready), .wr_job(push_job),
    .rd_valid(pop_valid), .rd_ready(pop_ready), .rd_job(pop_job),
    .level
  );

  hal_back u_back (
    .clk, .rst, .cfg,
    .job_valid(pop_valid), .job_ready(pop_ready), .job_in(pop_job),
    .clearing,
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_granted(granted), .out_status(status), .out_inflight(inflight)
  );

  assign m_tdata = {6'd0, inflight};
  assign m_tuser = {status, granted};

  a_grant_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (granted == (status == ST_GRANTED)))
    else $error("granted flag disagrees with status");

  a_grant_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && granted) |-> (inflight != 10'd0))
    else $error("grant reported with zero in-flight count");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!s_tready && !m_tvalid && level == 2'd0))
    else $error("traffic during clearing pass");

  a_queue_level: assert property (@(posedge clk) disable iff (rst)
    level != 2'd3)
    else $error("queue level out of range");

endmodule
`default_nettype wire

/* bench/handshake_admission_limiter_top_tb.sv */
// testbench for the handshake admission limiter: directed and random reserve/release
// traffic checked against an in-bench model of the bucket table; depends on hal_pkg and handshake_admission_limiter_top
`default_nettype none
module handshake_admission_limiter_top_tb;
  import hal_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [159:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [15:0]  m_tdata;
  logic [3:0]   m_tuser;

  handshake_admission_limiter_top DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  typedef struct packed {
    logic      granted;
    status_t   status;
    logic [9:0] inflight;
  } verdict_t;

  // model of the table and registers
  logic [63:0] tbl_hi [BUCKETS];
  logic [63:0] tbl_lo [BUCKETS];
  logic [31:0] tbl_ws [BUCKETS];
  logic [7:0]  tbl_cnt [BUCKETS];
  logic        tbl_used [BUCKETS];
  logic [9:0]  inflight;
  cfg_t        cfg;

  verdict_t verdict_q[$];
  int       errors = 0;
  int       sent = 0;
  bit       burst_on = 1'b1;
  int       burst_left = 0;

  function automatic verdict_t admit(logic rel, logic [63:0] khi, logic [63:0] klo,
                                     logic [31:0] now);
    verdict_t   v;
    logic [63:0] hi, lo;
    logic [31:0] h;
    logic [7:0] c;
    int         len, b, idx, stale_idx;
    bit         found, have_stale, stop;
    logic [BKT_W-1:0] start;
    v = '0;
    hi = '0;
    lo = '0;
    h = HASH_SEED;
    len = 0;
    found = 0;
    have_stale = 0;
    stop = 0;
    idx = 0;
    stale_idx = 0;
    if (rel) begin
      if (inflight > 0) begin
        inflight = inflight - 1;
        v.status = ST_RELEASED;
      end else begin
        v.status = ST_NONE;
      end
      v.inflight = inflight;
      return v;
    end
    for (int i = 0; i < KEY_BYTES; i++) begin
      c = (i < 8) ? khi[63 - 8*i -: 8] : klo[63 - 8*(i-8) -: 8];
      if (c == 8'h00) stop = 1;
      if (!stop) begin
        if (i < 8) hi[63 - 8*i -: 8] = c;
        else lo[63 - 8*(i-8) -: 8] = c;
        h = (h << 5) + h + c;
        len++;
      end
    end
    v.inflight = inflight;
    if (len == 0) begin
      v.status = ST_EMPTY_KEY;
      return v;
    end
    if (inflight >= cfg.max_global) begin
      v.status = ST_GLOBAL;
      return v;
    end
    start = h[BKT_W-1:0];
    for (int i = 0; i < BUCKETS && !found; i++) begin
      b = (start + i) % BUCKETS;
      if (tbl_used[b] && tbl_hi[b] == hi && tbl_lo[b] == lo) begin
        idx = b;
        found = 1;
      end else if (!tbl_used[b]) begin
        idx = b;
        found = 1;
        tbl_used[b] = 1;
        tbl_hi[b] = hi;
        tbl_lo[b] = lo;
        tbl_ws[b] = now;
        tbl_cnt[b] = 0;
      end else if (!have_stale && {1'b0, now} >= {1'b0, tbl_ws[b]} + cfg.bucket_ttl) begin
        have_stale = 1;
        stale_idx = b;
      end
    end
    if (!found && have_stale) begin
      idx = stale_idx;
      found = 1;
      tbl_hi[idx] = hi;
      tbl_lo[idx] = lo;
      tbl_ws[idx] = now;
      tbl_cnt[idx] = 0;
    end
    if (!found) begin
      v.status = ST_FULL;
      return v;
    end
    if ({1'b0, now} >= {1'b0, tbl_ws[idx]} + cfg.window_secs) begin
      tbl_ws[idx] = now;
      tbl_cnt[idx] = 0;
    end
    if (tbl_cnt[idx] >= cfg.max_per_window) begin
      v.status = ST_KEY_LIMIT;
      return v;
    end
    tbl_cnt[idx] = tbl_cnt[idx] + 1;
    inflight = inflight + 1;
    v.granted = 1'b1;
    v.status = ST_GRANTED;
    v.inflight = inflight;
    return v;
  endfunction

  // one transaction in, with bursts and gaps on the sending side
  task automatic send(logic rel, logic [63:0] khi, logic [63:0] klo, logic [31:0] now);
    if (burst_left == 0) begin
      burst_on = $urandom_range(0, 3) != 0;
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    if (!burst_on) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= rel;
    s_tdata <= {now, klo, khi};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    verdict_q.push_back(admit(rel, khi, klo, now));
    sent++;
  endtask

  task automatic write_reg(cfg_idx_t r, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (r)
      CFG_MAX_PER_WINDOW: cfg.max_per_window = val[7:0];
      CFG_MAX_GLOBAL:     cfg.max_global = val[9:0];
      CFG_WINDOW_SECS:    cfg.window_secs = val;
      default:            cfg.bucket_ttl = val;
    endcase
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // receiver stall pattern
  int stall_mode = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= $urandom_range(0, 1);
      default: m_tready <= $urandom_range(0, 4) == 0;
    endcase
  end

  // result checker
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result tuser=%h tdata=%h", $time, m_tuser, m_tdata);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (m_tuser[0] !== want.granted) begin
          $display("%0t: granted exp %0d got %0d", $time, want.granted, m_tuser[0]);
          errors++;
        end
        if (m_tuser[3:1] !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, m_tuser[3:1]);
          errors++;
        end
        if (m_tdata !== {6'd0, want.inflight}) begin
          $display("%0t: inflight exp %0d got %0d", $time, want.inflight, m_tdata);
          errors++;
        end
      end
    end
  end

  // small key pool so keys collide, repeat and hit their limits
  function automatic logic [63:0] pool_key(int n);
    logic [63:0] k;
    k = 64'h6b00_0000_0000_0000;
    k[55:48] = 8'h30 + n[7:0];
    return k;
  endfunction

  logic [31:0] clock_s = 32'd1000;

  task automatic random_reserve();
    logic [63:0] khi, klo;
    int sel;
    sel = $urandom_range(0, 9);
    klo = '0;
    if (sel < 7) begin
      khi = pool_key($urandom_range(0, 40));
    end else if (sel < 9) begin
      khi = {$urandom, $urandom};
      klo = {$urandom, $urandom};
    end else begin
      khi = '0;
      klo = {$urandom, $urandom};
    end
    if ($urandom_range(0, 3) == 0) clock_s = clock_s + $urandom_range(0, 200);
    send(1'b0, khi, klo, clock_s);
  endtask

  task automatic test_directed();
    send(1'b1, '0, '0, '0);                                // nothing to release
    send(1'b0, '0, 64'h4142, 32'd5);                       // empty key
    send(1'b0, '1, '1, '1);                                // full 16-byte key, max time
    send(1'b0, 64'h4100_FFFF_FFFF_FFFF, '1, 32'd7);         // trailing bytes ignored
    send(1'b0, 64'h4100_0000_0000_0000, '0, 32'd7);         // same key as above
    send(1'b0, 64'h4142_4344_4546_4748, 64'h4900_1234, 32'd0);
    send(1'b1, '1, '1, '1);
    drain();
    write_reg(CFG_MAX_PER_WINDOW, 16'd2);
    write_reg(CFG_WINDOW_SECS, 16'd10);
    for (int i = 0; i < 4; i++) send(1'b0, pool_key(1), '0, 32'd100);   // key limit
    send(1'b0, pool_key(1), '0, 32'd110);                               // window restarts
    drain();
    write_reg(CFG_MAX_GLOBAL, 16'd3);
    for (int i = 0; i < 4; i++) send(1'b0, pool_key(2 + i), '0, 32'd200); // global cap
    drain();
    write_reg(CFG_WINDOW_SECS, 16'hFFFF);
    write_reg(CFG_BUCKET_TTL, 16'hFFFF);
    write_reg(CFG_MAX_GLOBAL, 16'd1023);
    send(1'b0, pool_key(3), '0, 32'hFFFF_FFF0);
    send(1'b0, pool_key(3), '0, 32'hFFFF_FFFF);
    drain();
  endtask

  // fill the table with distinct keys so table-full and stale reclaim occur
  task automatic test_table_fill();
    write_reg(CFG_MAX_PER_WINDOW, 16'd255);
    write_reg(CFG_MAX_GLOBAL, 16'd1023);
    write_reg(CFG_BUCKET_TTL, 16'd50);
    for (int i = 0; i < 520; i++) begin
      send(1'b0, {8'h54, 8'h41 + {3'b0, i[9:5]}, 8'h41 + {3'b0, i[4:0]}, 40'h0},
           {32'h0, $urandom}, 32'd5000);
      if (i % 2 == 1) send(1'b1, '0, '0, '0);
    end
    send(1'b0, 64'h5a5a_0000_0000_0000, '0, 32'd5010);     // table full
    send(1'b0, 64'h5a5b_0000_0000_0000, '0, 32'd5100);     // reclaims a stale bucket
    drain();
  endtask

  task automatic test_random(int n, int mpw, int mg, int ws, int ttl);
    write_reg(CFG_MAX_PER_WINDOW, 16'(mpw));
    write_reg(CFG_MAX_GLOBAL, 16'(mg));
    write_reg(CFG_WINDOW_SECS, 16'(ws));
    write_reg(CFG_BUCKET_TTL, 16'(ttl));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) send(1'b1, {$urandom, $urandom}, {$urandom, $urandom},
                                          $urandom);
      else random_reserve();
    end
    drain();
  endtask

  initial begin
    cfg.max_per_window = 8'd30;
    cfg.max_global = 10'd256;
    cfg.window_secs = 16'd60;
    cfg.bucket_ttl = 16'd120;
    inflight = '0;
    for (int i = 0; i < BUCKETS; i++) begin
      tbl_used[i] = 0;
      tbl_hi[i] = '0;
      tbl_lo[i] = '0;
      tbl_ws[i] = '0;
      tbl_cnt[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(60, 30, 256, 60, 120);
    test_random(60, 1, 1, 1, 1);
    test_random(60, 255, 1023, 65535, 65535);
    test_random(60, 3, 8, 100, 300);
    test_table_fill();
    test_random(90, 5, 1023, 30, 60);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("handshake_admission_limiter_top test passed");
    end else begin
      $display("handshake_admission_limiter_top test failed");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("handshake_admission_limiter_top test failed");
    $finish;
  end
endmodule
`default_nettype wire
